/* rtl/stma_pkg.sv */
// Shared types and codes for the sparse triplet merge adder.
`default_nettype none
package stma_pkg;

    // One stored triplet, row-major key in the upper half.
    typedef struct packed {
        logic [15:0] row;
        logic [15:0] col;
        logic [31:0] value;
    } term_t;

    localparam int TERM_W = $bits(term_t);

    typedef logic [1:0] action_t;
    localparam action_t ACT_LOAD_A = 2'd0;
    localparam action_t ACT_LOAD_B = 2'd1;
    localparam action_t ACT_MERGE  = 2'd2;
    localparam action_t ACT_CLEAR  = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_TERM     = 2'd0;
    localparam status_t ST_MISMATCH = 2'd1;
    localparam status_t ST_DONE     = 2'd2;
    localparam status_t ST_DONE_OVF = 2'd3;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_A_ROWS = 2'd0;
    localparam cfg_index_t CFG_A_COLS = 2'd1;
    localparam cfg_index_t CFG_B_ROWS = 2'd2;
    localparam cfg_index_t CFG_B_COLS = 2'd3;

endpackage
`default_nettype wire

/* rtl/stma_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module stma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/sparse_triplet_merge_add.sv */
// Top level of the sparse matrix adder that merges two sorted triplet lists.
//
// Usage: terms of matrix A and matrix B are loaded one per transfer (action load A or
// load B) in row-major sorted order; loads and clears leave busy low, so a new
// command can follow in the very next cycle. A merge step begins with the transfer,
// in which both term stores are read at their merge positions; in the busy cycle
// after it the two head terms are compared and the result is registered. The result
// then sits on the output ports for exactly one cycle with strobe high; the receiver
// cannot stall it, so it must take it in that cycle. Merge steps therefore do not
// overlap, as start is ignored while busy and the term stores have a registered read
// port. A step whose positions match and whose sum is zero gives no strobe at all. The
// merge ends with a done result (status 2, or 3 if a load was dropped because a store
// was full), or status 1 if the dimensions differ while a store holds terms, carrying
// last; the next step starts over from the first terms. Configuration writes of the
// dimension registers are always ready and must only be made while the block is idle.
`default_nettype none
module sparse_triplet_merge_add
    import stma_pkg::*;
#(
    parameter int TERM_DEPTH = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Command channel.
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic [15:0]        term_row,
    input  wire logic [15:0]        term_col,
    input  wire logic signed [31:0] term_value,
    // Configuration channel.
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    // Result channel.
    output logic                    strobe,
    output logic [15:0]             out_row,
    output logic [15:0]             out_col,
    output logic signed [31:0]      out_value,
    output logic [1:0]              status,
    output logic                    last
);

    localparam int AW = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
    localparam int CW = $clog2(TERM_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(TERM_DEPTH);

    // Dimension registers.
    logic [15:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;

    // Merge bookkeeping.
    logic [CW-1:0] a_count_reg, a_count_next;
    logic [CW-1:0] b_count_reg, b_count_next;
    logic [CW-1:0] a_ptr_reg, a_ptr_next;
    logic [CW-1:0] b_ptr_reg, b_ptr_next;
    logic          ovf_reg, ovf_next;
    logic          busy_reg, busy_next;

    // Result register.
    logic          strobe_reg, strobe_next;
    term_t         res_reg, res_next;
    status_t       status_reg, status_next;
    logic          last_reg, last_next;

    // Store ports.
    logic          a_wr_en, b_wr_en;
    term_t         wr_term;
    logic [TERM_W-1:0] a_rd_data, b_rd_data;
    term_t         a_head, b_head;

    logic          accept;
    logic          a_live, b_live, dims_ok, both_empty;
    logic [31:0]   a_key, b_key, sum;

    assign accept    = start & ~busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    assign wr_term = '{row: term_row, col: term_col, value: term_value};
    assign a_head  = term_t'(a_rd_data);
    assign b_head  = term_t'(b_rd_data);

    stma_ram #(.WIDTH(TERM_W), .DEPTH(TERM_DEPTH)) u_a_store (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (a_count_reg[AW-1:0]),
        .wr_data (wr_term),
        .rd_addr (a_ptr_reg[AW-1:0]),
        .rd_data (a_rd_data)
    );

    stma_ram #(.WIDTH(TERM_W), .DEPTH(TERM_DEPTH)) u_b_store (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (b_count_reg[AW-1:0]),
        .wr_data (wr_term),
        .rd_addr (b_ptr_reg[AW-1:0]),
        .rd_data (b_rd_data)
    );

    // Head comparison. The read pointers are stable during the busy cycle, so the
    // store outputs hold exactly the two head terms.
    assign a_live     = a_ptr_reg < a_count_reg;
    assign b_live     = b_ptr_reg < b_count_reg;
    assign both_empty = (a_count_reg == '0) && (b_count_reg == '0);
    assign dims_ok    = (a_rows_reg == b_rows_reg) && (a_cols_reg == b_cols_reg);
    assign a_key      = {a_head.row, a_head.col};
    assign b_key      = {b_head.row, b_head.col};
    assign sum        = a_head.value + b_head.value;

    always_comb
    begin
        a_count_next = a_count_reg;
        b_count_next = b_count_reg;
        a_ptr_next   = a_ptr_reg;
        b_ptr_next   = b_ptr_reg;
        ovf_next     = ovf_reg;
        busy_next    = 1'b0;
        strobe_next  = 1'b0;
        res_next     = res_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        a_wr_en      = 1'b0;
        b_wr_en      = 1'b0;

        if (accept)
        begin
            unique case (action)
                ACT_LOAD_A:
                begin
                    if (a_count_reg < FULL)
                    begin
                        a_wr_en      = 1'b1;
                        a_count_next = a_count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                ACT_LOAD_B:
                begin
                    if (b_count_reg < FULL)
                    begin
                        b_wr_en      = 1'b1;
                        b_count_next = b_count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                ACT_MERGE:
                begin
                    busy_next = 1'b1;
                end
                ACT_CLEAR:
                begin
                    a_count_next = '0;
                    b_count_next = '0;
                    a_ptr_next   = '0;
                    b_ptr_next   = '0;
                    ovf_next     = 1'b0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end

        if (busy_reg)
        begin
            // Default to an ordinary term result from A's head.
            status_next = ST_TERM;
            last_next   = 1'b0;
            res_next    = a_head;
            strobe_next = 1'b1;
            if (!both_empty && !dims_ok)
            begin
                a_ptr_next  = '0;
                b_ptr_next  = '0;
                res_next    = '0;
                status_next = ST_MISMATCH;
                last_next   = 1'b1;
            end
            else if (!a_live && !b_live)
            begin
                a_ptr_next  = '0;
                b_ptr_next  = '0;
                res_next    = '0;
                status_next = ovf_reg ? ST_DONE_OVF : ST_DONE;
                last_next   = 1'b1;
            end
            else if (!b_live || (a_live && a_key < b_key))
            begin
                a_ptr_next = a_ptr_reg + 1'b1;
            end
            else if (!a_live || a_key > b_key)
            begin
                res_next   = b_head;
                b_ptr_next = b_ptr_reg + 1'b1;
            end
            else
            begin
                // Same position: emit the sum unless it cancels out.
                a_ptr_next     = a_ptr_reg + 1'b1;
                b_ptr_next     = b_ptr_reg + 1'b1;
                res_next.value = sum;
                strobe_next    = (sum != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_count_reg <= '0;
            b_count_reg <= '0;
            a_ptr_reg   <= '0;
            b_ptr_reg   <= '0;
            ovf_reg     <= 1'b0;
            busy_reg    <= 1'b0;
            strobe_reg  <= 1'b0;
            a_rows_reg  <= 16'd1;
            a_cols_reg  <= 16'd1;
            b_rows_reg  <= 16'd1;
            b_cols_reg  <= 16'd1;
        end
        else
        begin
            a_count_reg <= a_count_next;
            b_count_reg <= b_count_next;
            a_ptr_reg   <= a_ptr_next;
            b_ptr_reg   <= b_ptr_next;
            ovf_reg     <= ovf_next;
            busy_reg    <= busy_next;
            strobe_reg  <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_A_ROWS: a_rows_reg <= cfg_data;
                    CFG_A_COLS: a_cols_reg <= cfg_data;
                    CFG_B_ROWS: b_rows_reg <= cfg_data;
                    CFG_B_COLS: b_cols_reg <= cfg_data;
                    default:    a_rows_reg <= a_rows_reg;
                endcase
            end
        end
    end

    // Result payload needs no reset; strobe qualifies it.
    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign strobe    = strobe_reg;
    assign out_row   = res_reg.row;
    assign out_col   = res_reg.col;
    assign out_value = res_reg.value;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire
